>>> rtl/rsp_pkg.sv
// Shared constants and the GF(256) multiply for the Reed-Solomon parity encoder.
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W = 6;

    // Field polynomial x^8+x^4+x^3+x^2+1 and the primitive element.
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [BYTE_W-1:0] GF_ALPHA = 8'h02;

    localparam int RESET_COUNT = 10;

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
                                                 input logic [BYTE_W-1:0] y);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] p;
        a = x;
        p = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (y[k]) begin
                p = p ^ a;
            end
            a = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? GF_POLY[BYTE_W-1:0] : 8'h00);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rsp_if.sv
// Handshake interfaces for the data, parity and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface rsp_data_if;
    import rsp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rsp_par_if;
    import rsp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] parity_byte;
    logic              last_parity;
    modport source (output valid, output parity_byte, output last_parity, input ready);
    modport sink (input valid, input parity_byte, input last_parity, output ready);
endinterface

interface rsp_cfg_if;
    import rsp_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] parity_count;
    modport source (output valid, output parity_count, input ready);
    modport sink (input valid, input parity_count, output ready);
endinterface

`default_nettype wire

>>> rtl/reed_solomon_parity_encoder.sv
// Top level of the systematic Reed-Solomon parity encoder over GF(256).
// Data words are absorbed at one per clock, when not stalled, into a remainder
// LFSR with one GF(256) multiplier per tap; a word marked last moves the
// finished remainder into a two-entry queue and the LFSR restarts empty on the
// next clock. The back end sends the n parity words of each block, highest
// order first, one per clock while the sink is ready, through an output
// register. Input stalls only when both queue entries are occupied, while a
// write of the parity count is offered, or while the generator is built.
// After reset, and after every write of the parity count, the generator
// polynomial is built one root per clock on the shared tap multipliers,
// during which no data word is taken; a count below 2 is taken as 2 and one
// above MAX_PARITY as MAX_PARITY.
`timescale 1ns / 1ps
`default_nettype none

module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rsp_cfg_if.sink   i_cfg,
    rsp_data_if.sink  i_data,
    rsp_par_if.source o_parity
);
    import rsp_pkg::*;

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int W  = MAX_PARITY * BYTE_W;

    logic          push_valid, push_ready;
    logic [W-1:0]  push_rem;
    logic          head_valid, pop;
    logic [W-1:0]  head;
    logic [CW-1:0] count;

    rsp_front #(.MAX_PARITY(MAX_PARITY)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_data       (i_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_rem   (push_rem),
        .o_count      (count)
    );

    rsp_queue #(.WIDTH(W)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_rem),
        .o_pop_valid  (head_valid),
        .i_pop        (pop),
        .o_pop_data   (head)
    );

    rsp_back #(.MAX_PARITY(MAX_PARITY)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_count      (count),
        .o_par        (o_parity)
    );

endmodule

`default_nettype wire

>>> rtl/rsp_front.sv
// Front end: parity count register, generator build and the remainder LFSR.
`timescale 1ns / 1ps
`default_nettype none

module rsp_front #(
    parameter int MAX_PARITY = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    rsp_cfg_if.sink                                    i_cfg,
    rsp_data_if.sink                                   i_data,
    output logic                                       o_push_valid,
    input  wire logic                                  i_push_ready,
    output logic [MAX_PARITY*rsp_pkg::BYTE_W-1:0]      o_push_rem,
    output logic [$clog2(MAX_PARITY+1)-1:0]            o_count
);
    import rsp_pkg::*;

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int RST_CNT = (RESET_COUNT > MAX_PARITY) ? MAX_PARITY : RESET_COUNT;

    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_step, n_step;
    logic              r_build, n_build;
    logic [BYTE_W-1:0] r_root, n_root;
    logic [BYTE_W-1:0] r_gen [MAX_PARITY];
    logic [BYTE_W-1:0] n_gen [MAX_PARITY];
    logic [BYTE_W-1:0] r_rem [MAX_PARITY];
    logic [BYTE_W-1:0] n_rem [MAX_PARITY];
    logic [BYTE_W-1:0] prod [MAX_PARITY];
    logic [BYTE_W-1:0] step_gen [MAX_PARITY];
    logic [BYTE_W-1:0] step_rem [MAX_PARITY];
    logic [BYTE_W-1:0] factor;
    logic [BYTE_W-1:0] mul_b;
    logic [CW-1:0]     wr_count;
    logic              cfg_wr;
    logic              accept;

    // A count write takes priority, so no data word is taken in the same cycle.
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr       = i_cfg.valid && i_cfg.ready;
    assign i_data.ready = !r_build && i_push_ready && !i_cfg.valid;
    assign accept       = i_data.valid && i_data.ready;
    assign o_push_valid = accept && i_data.last_byte;
    assign o_count      = r_count;

    always_comb begin
        if (i_cfg.parity_count < CFG_W'(2)) begin
            wr_count = CW'(2);
        end else if (int'(i_cfg.parity_count) > MAX_PARITY) begin
            wr_count = CW'(MAX_PARITY);
        end else begin
            wr_count = CW'(i_cfg.parity_count);
        end
    end

    // One multiplier per tap, shared: it multiplies by the current root while the
    // generator is being built and by the feedback byte while data is absorbed.
    // Entries at or beyond the count stay zero, so every tap uses the same rule.
    assign factor = i_data.data_byte ^ r_rem[0];
    assign mul_b  = r_build ? r_root : factor;

    always_comb begin
        for (int j = 0; j < MAX_PARITY; j++) begin
            prod[j] = gf_mul(r_gen[j], mul_b);
            if (j < MAX_PARITY - 1) begin
                step_gen[j] = prod[j] ^ r_gen[j+1];
                step_rem[j] = prod[j] ^ r_rem[j+1];
            end else begin
                step_gen[j] = prod[j];
                step_rem[j] = prod[j];
            end
            o_push_rem[j*BYTE_W +: BYTE_W] = step_rem[j];
        end
    end

    always_comb begin
        n_count = r_count;
        n_step  = r_step;
        n_build = r_build;
        n_root  = r_root;
        n_gen   = r_gen;
        n_rem   = r_rem;
        if (cfg_wr) begin
            n_count = wr_count;
            n_step  = '0;
            n_build = 1'b1;
            n_root  = 8'h01;
            for (int j = 0; j < MAX_PARITY; j++) begin
                n_gen[j] = (j == int'(wr_count) - 1) ? 8'h01 : 8'h00;
                n_rem[j] = '0;
            end
        end else if (r_build) begin
            n_gen  = step_gen;
            n_root = gf_mul(r_root, GF_ALPHA);
            n_step = r_step + CW'(1);
            if (r_step == r_count - CW'(1)) begin
                n_build = 1'b0;
            end
        end else if (accept) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
                n_rem[j] = i_data.last_byte ? 8'h00 : step_rem[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(RST_CNT);
            r_step  <= '0;
            r_build <= 1'b1;
            r_root  <= 8'h01;
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_gen[j] <= (j == RST_CNT - 1) ? 8'h01 : 8'h00;
                r_rem[j] <= '0;
            end
        end else begin
            r_count <= n_count;
            r_step  <= n_step;
            r_build <= n_build;
            r_root  <= n_root;
            r_gen   <= n_gen;
            r_rem   <= n_rem;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rsp_queue.sv
// Two-entry queue of finished remainders between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module rsp_queue #(
    parameter int WIDTH = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_pop_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

>>> rtl/rsp_back.sv
// Back end: walks the queued remainder and drives the registered parity output.
`timescale 1ns / 1ps
`default_nettype none

module rsp_back #(
    parameter int MAX_PARITY = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_head_valid,
    input  wire logic [MAX_PARITY*rsp_pkg::BYTE_W-1:0] i_head,
    output logic                                       o_pop,
    input  wire logic [$clog2(MAX_PARITY+1)-1:0]       i_count,
    rsp_par_if.source                                  o_par
);
    import rsp_pkg::*;

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    logic [IW-1:0]     r_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              take;
    logic              at_end;

    assign take   = !r_valid || o_par.ready;
    assign at_end = (CW'(r_idx) == i_count - CW'(1));
    assign o_pop  = i_head_valid && take && at_end;

    assign o_par.valid       = r_valid;
    assign o_par.parity_byte = r_byte;
    assign o_par.last_parity = r_last;

    always_ff @(posedge i_clk) begin
        if (i_head_valid && take) begin
            r_byte <= i_head[r_idx*BYTE_W +: BYTE_W];
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_head_valid && take) begin
            r_valid <= 1'b1;
            r_idx   <= at_end ? '0 : r_idx + IW'(1);
        end else if (o_par.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rsp_checker.sv
// Port-level assertions for the parity encoder and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module rsp_checker #(
    parameter int MAX_PARITY = 32
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_cfg_valid,
    input wire logic                       i_cfg_ready,
    input wire logic [rsp_pkg::CFG_W-1:0]  i_cfg_count,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_in_last,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [rsp_pkg::BYTE_W-1:0] i_out_byte,
    input wire logic                       i_out_last
);
    import rsp_pkg::*;

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int RST_CNT = (RESET_COUNT > MAX_PARITY) ? MAX_PARITY : RESET_COUNT;

    logic [CW-1:0] r_n;
    logic [CW-1:0] r_sent;
    logic [7:0]    r_pend;
    logic          cfg_wr, in_end, out_acc, out_end;

    assign cfg_wr  = i_cfg_valid && i_cfg_ready;
    assign in_end  = i_in_valid && i_in_ready && i_in_last;
    assign out_acc = i_out_valid && i_out_ready;
    assign out_end = out_acc && i_out_last;

    // Track the configured count, the words sent in the current block and the
    // number of blocks whose parity is still owed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= CW'(RST_CNT);
            r_sent <= '0;
            r_pend <= '0;
        end else begin
            if (cfg_wr) begin
                if (i_cfg_count < CFG_W'(2)) begin
                    r_n <= CW'(2);
                end else if (int'(i_cfg_count) > MAX_PARITY) begin
                    r_n <= CW'(MAX_PARITY);
                end else begin
                    r_n <= CW'(i_cfg_count);
                end
            end
            if (out_acc) begin
                r_sent <= out_end ? '0 : r_sent + CW'(1);
            end
            r_pend <= r_pend + {7'b0, in_end} - {7'b0, out_end};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)))
        else $error("parity word changed while stalled");

    a_build_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !i_in_ready)
        else $error("data taken while the generator is being rebuilt");

    a_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_end |-> (r_pend != 8'd0))
        else $error("parity block sent without a finished data block");

    a_len_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_end |-> (r_sent + CW'(1) == r_n))
        else $error("parity block length differs from the configured count");

    a_len_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !i_out_last) |-> (r_sent + CW'(1) < r_n))
        else $error("parity block runs past the configured count");

endmodule

bind reed_solomon_parity_encoder rsp_checker #(.MAX_PARITY(MAX_PARITY)) u_rsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_count (i_cfg.parity_count),
    .i_in_valid  (i_data.valid),
    .i_in_ready  (i_data.ready),
    .i_in_last   (i_data.last_byte),
    .i_out_valid (o_parity.valid),
    .i_out_ready (o_parity.ready),
    .i_out_byte  (o_parity.parity_byte),
    .i_out_last  (o_parity.last_parity)
);

`default_nettype wire
